### sv/lsbs_pkg.sv
`default_nettype none

package lsbs_pkg;

  // default widths for the elapsed-time counters and the pulse count
  localparam int TimerWidthDefault = 16;
  localparam int CountWidthDefault = 16;

  // fixed widths of the word fields and the register port
  localparam int FieldWidth    = 16;
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  // register reset values
  localparam logic                  LedsEnabledReset  = 1'b1;
  localparam logic [FieldWidth-1:0] MinFrameReset     = 16'd3;
  localparam logic [FieldWidth-1:0] IndDelayReset     = 16'd3000;
  localparam logic [FieldWidth-1:0] PulseIntervalReset = 16'd2000;
  localparam logic [FieldWidth-1:0] PulseLengthReset  = 16'd180;
  localparam logic [FieldWidth-1:0] ScanBlinkReset    = 16'd300;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_SCAN = 2'd1,
    MODE_BUSY = 2'd2,
    MODE_IDLE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    COLOUR_OFF  = 2'd0,
    COLOUR_SCAN = 2'd1,
    COLOUR_IDLE = 2'd2
  } colour_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_ARM  = 1'b1
  } op_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_LEDS_ENABLED   = 3'd0,
    REG_MIN_FRAME      = 3'd1,
    REG_IND_DELAY      = 3'd2,
    REG_PULSE_INTERVAL = 3'd3,
    REG_PULSE_LENGTH   = 3'd4,
    REG_SCAN_BLINK     = 3'd5
  } cfg_reg_t;

  // colour written on entry to a mode
  function automatic colour_t colour_for_mode(input mode_t m);
    colour_t c;
    unique case (m)
      MODE_SCAN: c = COLOUR_SCAN;
      MODE_IDLE: c = COLOUR_IDLE;
      default:   c = COLOUR_OFF;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/led_status_blink_sequencer_core.sv
`default_nettype none

// Status LED sequencer. Each input word is either a millisecond tick (with the
// busy, scan and frame-count status) or an arm command for the pulse-count
// indicator; every word gives exactly one result word with the current mode,
// the colour shown and a flag saying the colour was written on that step.
// One word is taken every clock cycle while in_stall is low: the accepted word
// sits in an input register, and once the result register is free or being
// read, a single pass of compare and counter logic updates the sequencer state
// and loads the result register. A result waiting on a stalled output does not
// block the input until the input register is also full. The user must write
// registers through the configuration port only while no word is in flight;
// the block itself does not enforce this. Writes to indexes beyond the register
// list are ignored.
module led_status_blink_sequencer_core #(
  parameter int TIMER_WIDTH = lsbs_pkg::TimerWidthDefault,
  parameter int COUNT_WIDTH = lsbs_pkg::CountWidthDefault
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration write channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [lsbs_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  wire logic [lsbs_pkg::CfgDataWidth-1:0]    cfg_data,
  // input words
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 operation,
  input  wire logic [lsbs_pkg::FieldWidth-1:0]      target_count,
  input  wire logic                                 busy_running,
  input  wire logic                                 scan_running,
  input  wire logic [lsbs_pkg::FieldWidth-1:0]      frame_count,
  // result words
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [1:0]                                status_mode,
  output logic [1:0]                                colour_code,
  output logic                                      colour_write
);

  localparam int FW    = lsbs_pkg::FieldWidth;
  localparam int CMP_W = (TIMER_WIDTH > FW) ? TIMER_WIDTH : FW;

  // configuration registers
  logic          leds_enabled;
  logic [FW-1:0] min_frame_threshold;
  logic [FW-1:0] indicator_delay_ticks;
  logic [FW-1:0] pulse_interval_ticks;
  logic [FW-1:0] pulse_length_ticks;
  logic [FW-1:0] scan_blink_ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      leds_enabled          <= lsbs_pkg::LedsEnabledReset;
      min_frame_threshold   <= lsbs_pkg::MinFrameReset;
      indicator_delay_ticks <= lsbs_pkg::IndDelayReset;
      pulse_interval_ticks  <= lsbs_pkg::PulseIntervalReset;
      pulse_length_ticks    <= lsbs_pkg::PulseLengthReset;
      scan_blink_ticks      <= lsbs_pkg::ScanBlinkReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsbs_pkg::REG_LEDS_ENABLED:   leds_enabled          <= cfg_data[0];
        lsbs_pkg::REG_MIN_FRAME:      min_frame_threshold   <= cfg_data;
        lsbs_pkg::REG_IND_DELAY:      indicator_delay_ticks <= cfg_data;
        lsbs_pkg::REG_PULSE_INTERVAL: pulse_interval_ticks  <= cfg_data;
        lsbs_pkg::REG_PULSE_LENGTH:   pulse_length_ticks    <= cfg_data;
        lsbs_pkg::REG_SCAN_BLINK:     scan_blink_ticks      <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic          in_full;
  lsbs_pkg::op_t op_r;
  logic [FW-1:0] target_r;
  logic          busy_r;
  logic          scan_r;
  logic [FW-1:0] frames_r;
  logic          advance;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r     <= lsbs_pkg::op_t'(operation);
      target_r <= target_count;
      busy_r   <= busy_running;
      scan_r   <= scan_running;
      frames_r <= frame_count;
    end
  end

  // sequencer state
  lsbs_pkg::mode_t        mode_reg, mode_next;
  lsbs_pkg::colour_t      shown_colour, colour_next;
  logic                   scan_lit, scan_lit_next;
  logic [TIMER_WIDTH-1:0] scan_elapsed, scan_elapsed_next;
  logic                   ind_active, ind_active_next;
  logic                   ind_pulse_lit, ind_pulse_lit_next;
  logic [COUNT_WIDTH-1:0] ind_target, ind_target_next;
  logic [COUNT_WIDTH-1:0] ind_done, ind_done_next;
  logic [TIMER_WIDTH-1:0] since_arm, since_arm_next;
  logic [TIMER_WIDTH-1:0] since_pulse_start, since_pulse_start_next;
  logic                   pulsed_once, pulsed_once_next;
  logic                   wrote;
  logic                   step;

  assign step = in_full && advance;

  function automatic logic [TIMER_WIDTH-1:0] sat_inc(input logic [TIMER_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // one pass over the word: counters, mode pick, indicator and blink
  always_comb begin
    mode_next              = mode_reg;
    colour_next            = shown_colour;
    scan_lit_next          = scan_lit;
    scan_elapsed_next      = scan_elapsed;
    ind_active_next        = ind_active;
    ind_pulse_lit_next     = ind_pulse_lit;
    ind_target_next        = ind_target;
    ind_done_next          = ind_done;
    since_arm_next         = since_arm;
    since_pulse_start_next = since_pulse_start;
    pulsed_once_next       = pulsed_once;
    wrote                  = 1'b0;

    if (step) begin
      if (op_r == lsbs_pkg::OP_ARM) begin
        ind_target_next        = target_r[COUNT_WIDTH-1:0];
        ind_done_next          = '0;
        since_arm_next         = '0;
        since_pulse_start_next = '0;
        pulsed_once_next       = 1'b0;
        ind_pulse_lit_next     = 1'b0;
        ind_active_next        = |target_r[COUNT_WIDTH-1:0];
      end else begin
        scan_elapsed_next      = sat_inc(scan_elapsed);
        since_arm_next         = sat_inc(since_arm);
        since_pulse_start_next = sat_inc(since_pulse_start);

        priority if (!leds_enabled) begin
          scan_lit_next      = 1'b0;
          ind_active_next    = 1'b0;
          ind_pulse_lit_next = 1'b0;
          if (mode_reg != lsbs_pkg::MODE_OFF) begin
            mode_next   = lsbs_pkg::MODE_OFF;
            colour_next = lsbs_pkg::colour_for_mode(lsbs_pkg::MODE_OFF);
            wrote       = 1'b1;
          end
        end else if (busy_r) begin
          scan_lit_next = 1'b0;
          if (mode_reg != lsbs_pkg::MODE_BUSY) begin
            mode_next   = lsbs_pkg::MODE_BUSY;
            colour_next = lsbs_pkg::colour_for_mode(lsbs_pkg::MODE_BUSY);
            wrote       = 1'b1;
          end
          // count indicator
          if (ind_active &&
              CMP_W'(since_arm_next) >= CMP_W'(indicator_delay_ticks)) begin
            if (ind_pulse_lit) begin
              if (CMP_W'(since_pulse_start_next) >= CMP_W'(pulse_length_ticks)) begin
                ind_pulse_lit_next = 1'b0;
                colour_next        = lsbs_pkg::COLOUR_OFF;
                wrote              = 1'b1;
              end
            end else if (ind_done < ind_target) begin
              if (!pulsed_once ||
                  CMP_W'(since_pulse_start_next) >= CMP_W'(pulse_interval_ticks)) begin
                pulsed_once_next       = 1'b1;
                since_pulse_start_next = '0;
                ind_pulse_lit_next     = 1'b1;
                ind_done_next          = ind_done + 1'b1;
                colour_next            = lsbs_pkg::COLOUR_IDLE;
                wrote                  = 1'b1;
              end
            end else begin
              ind_active_next = 1'b0;
              colour_next     = lsbs_pkg::COLOUR_OFF;
              wrote           = 1'b1;
            end
          end
        end else if (scan_r && frames_r < min_frame_threshold) begin
          ind_active_next    = 1'b0;
          ind_pulse_lit_next = 1'b0;
          if (mode_reg != lsbs_pkg::MODE_SCAN) begin
            mode_next   = lsbs_pkg::MODE_SCAN;
            colour_next = lsbs_pkg::colour_for_mode(lsbs_pkg::MODE_SCAN);
            wrote       = 1'b1;
          end
          // scan blink toggle
          if (CMP_W'(scan_elapsed_next) >= CMP_W'(scan_blink_ticks)) begin
            scan_elapsed_next = '0;
            scan_lit_next     = !scan_lit;
            colour_next       = scan_lit ? lsbs_pkg::COLOUR_OFF : lsbs_pkg::COLOUR_SCAN;
            wrote             = 1'b1;
          end
        end else begin
          scan_lit_next      = 1'b0;
          ind_active_next    = 1'b0;
          ind_pulse_lit_next = 1'b0;
          if (mode_reg != lsbs_pkg::MODE_IDLE) begin
            mode_next   = lsbs_pkg::MODE_IDLE;
            colour_next = lsbs_pkg::colour_for_mode(lsbs_pkg::MODE_IDLE);
            wrote       = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg          <= lsbs_pkg::MODE_OFF;
      shown_colour      <= lsbs_pkg::COLOUR_OFF;
      scan_lit          <= 1'b0;
      scan_elapsed      <= '0;
      ind_active        <= 1'b0;
      ind_pulse_lit     <= 1'b0;
      ind_target        <= '0;
      ind_done          <= '0;
      since_arm         <= '0;
      since_pulse_start <= '0;
      pulsed_once       <= 1'b0;
    end else begin
      mode_reg          <= mode_next;
      shown_colour      <= colour_next;
      scan_lit          <= scan_lit_next;
      scan_elapsed      <= scan_elapsed_next;
      ind_active        <= ind_active_next;
      ind_pulse_lit     <= ind_pulse_lit_next;
      ind_target        <= ind_target_next;
      ind_done          <= ind_done_next;
      since_arm         <= since_arm_next;
      since_pulse_start <= since_pulse_start_next;
      pulsed_once       <= pulsed_once_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      status_mode  <= mode_next;
      colour_code  <= colour_next;
      colour_write <= wrote;
    end
  end

  // checks on the sequencer state
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty result register");

  a_pulse_needs_active: assert property (@(posedge clk) disable iff (rst)
    ind_pulse_lit |-> ind_active)
    else $error("indicator pulse lit while indicator inactive");

  a_done_bounded: assert property (@(posedge clk) disable iff (rst)
    ind_done <= ind_target)
    else $error("indicator pulse count beyond target");

  a_scan_colour: assert property (@(posedge clk) disable iff (rst)
    mode_reg == lsbs_pkg::MODE_SCAN |-> shown_colour != lsbs_pkg::COLOUR_IDLE)
    else $error("idle colour shown in scan mode");

  a_off_dark: assert property (@(posedge clk) disable iff (rst)
    mode_reg == lsbs_pkg::MODE_OFF |-> shown_colour == lsbs_pkg::COLOUR_OFF)
    else $error("colour lit in off mode");

endmodule

`default_nettype wire

### sim/tb_led_status_blink_sequencer_core.sv
module tb_led_status_blink_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 2_000_000;
  localparam int PhaseWords  = 250;
  localparam logic [15:0] TimerMax = 16'hFFFF;

  typedef struct packed {
    lsbs_pkg::op_t op;
    logic [15:0]   target;
    logic          busy;
    logic          scan;
    logic [15:0]   frames;
  } word_t;

  typedef struct packed {
    lsbs_pkg::mode_t   mode;
    lsbs_pkg::colour_t colour;
    logic              wrote;
  } result_t;

  typedef struct {
    logic               is_reg;
    lsbs_pkg::cfg_reg_t reg_idx;
    logic [15:0]        reg_val;
    word_t              w;
    logic               typed;
    result_t            exp;
  } dir_row_t;

  // clock, reset and block ports
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  lsbs_pkg::cfg_reg_t cfg_index = lsbs_pkg::REG_LEDS_ENABLED;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  lsbs_pkg::op_t      operation = lsbs_pkg::OP_TICK;
  logic [15:0]        target_count = '0;
  logic               busy_running = 1'b0;
  logic               scan_running = 1'b0;
  logic [15:0]        frame_count = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status_mode;
  logic [1:0]         colour_code;
  logic               colour_write;

  // shadow copy of the registers
  logic        cfg_enabled;
  logic [15:0] cfg_min_frame;
  logic [15:0] cfg_delay;
  logic [15:0] cfg_interval;
  logic [15:0] cfg_length;
  logic [15:0] cfg_blink;

  // shadow copy of the sequencer state
  lsbs_pkg::mode_t   seq_mode;
  lsbs_pkg::colour_t seq_colour;
  logic              seq_wrote;
  logic              seq_scan_lit;
  logic [15:0]       seq_scan_elapsed;
  logic              seq_ind_active;
  logic              seq_pulse_lit;
  logic [15:0]       seq_target;
  logic [15:0]       seq_done;
  logic [15:0]       seq_since_arm;
  logic [15:0]       seq_since_pulse;
  logic              seq_pulsed_once;

  result_t     expected_q[$];
  dir_row_t    dir_rows[$];
  int          gap_pct = 36;
  int          stall_pct = 62;
  int unsigned fails = 0;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int unsigned arms_sent = 0;
  int unsigned results_seen = 0;
  int unsigned colour_writes_seen = 0;
  int unsigned reg_writes = 0;

  led_status_blink_sequencer_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .target_count (target_count),
    .busy_running (busy_running),
    .scan_running (scan_running),
    .frame_count  (frame_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status_mode  (status_mode),
    .colour_code  (colour_code),
    .colour_write (colour_write)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_led_status_blink_sequencer_core NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer predictor
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] sat_up(input logic [15:0] v);
    return (v == TimerMax) ? v : v + 16'd1;
  endfunction

  function automatic void show(input lsbs_pkg::colour_t c);
    seq_colour = c;
    seq_wrote  = 1'b1;
  endfunction

  // a change of mode repaints the led in that mode's colour
  function automatic void switch_mode(input lsbs_pkg::mode_t m);
    if (m != seq_mode) begin
      seq_mode = m;
      case (m)
        lsbs_pkg::MODE_SCAN: show(lsbs_pkg::COLOUR_SCAN);
        lsbs_pkg::MODE_IDLE: show(lsbs_pkg::COLOUR_IDLE);
        default:             show(lsbs_pkg::COLOUR_OFF);
      endcase
    end
  endfunction

  function automatic void clear_sequencer();
    seq_mode         = lsbs_pkg::MODE_OFF;
    seq_colour       = lsbs_pkg::COLOUR_OFF;
    seq_wrote        = 1'b0;
    seq_scan_lit     = 1'b0;
    seq_scan_elapsed = '0;
    seq_ind_active   = 1'b0;
    seq_pulse_lit    = 1'b0;
    seq_target       = '0;
    seq_done         = '0;
    seq_since_arm    = '0;
    seq_since_pulse  = '0;
    seq_pulsed_once  = 1'b0;
    cfg_enabled      = lsbs_pkg::LedsEnabledReset;
    cfg_min_frame    = lsbs_pkg::MinFrameReset;
    cfg_delay        = lsbs_pkg::IndDelayReset;
    cfg_interval     = lsbs_pkg::PulseIntervalReset;
    cfg_length       = lsbs_pkg::PulseLengthReset;
    cfg_blink        = lsbs_pkg::ScanBlinkReset;
  endfunction

  function automatic result_t predict_word(input word_t w);
    result_t r;
    seq_wrote = 1'b0;
    if (w.op == lsbs_pkg::OP_ARM) begin
      // arming only loads the indicator
      seq_target      = w.target;
      seq_done        = '0;
      seq_since_arm   = '0;
      seq_since_pulse = '0;
      seq_pulsed_once = 1'b0;
      seq_pulse_lit   = 1'b0;
      seq_ind_active  = (w.target != '0);
    end else begin
      seq_scan_elapsed = sat_up(seq_scan_elapsed);
      seq_since_arm    = sat_up(seq_since_arm);
      seq_since_pulse  = sat_up(seq_since_pulse);
      if (!cfg_enabled) begin
        seq_scan_lit   = 1'b0;
        seq_ind_active = 1'b0;
        seq_pulse_lit  = 1'b0;
        switch_mode(lsbs_pkg::MODE_OFF);
      end else if (w.busy) begin
        seq_scan_lit = 1'b0;
        switch_mode(lsbs_pkg::MODE_BUSY);
        // count indicator: delay, then lit pulses spaced by the interval
        if (seq_ind_active && seq_since_arm >= cfg_delay) begin
          if (seq_pulse_lit) begin
            if (seq_since_pulse >= cfg_length) begin
              seq_pulse_lit = 1'b0;
              show(lsbs_pkg::COLOUR_OFF);
            end
          end else if (seq_done < seq_target) begin
            if (!seq_pulsed_once || seq_since_pulse >= cfg_interval) begin
              seq_pulsed_once = 1'b1;
              seq_since_pulse = '0;
              seq_pulse_lit   = 1'b1;
              seq_done        = seq_done + 16'd1;
              show(lsbs_pkg::COLOUR_IDLE);
            end
          end else begin
            seq_ind_active = 1'b0;
            show(lsbs_pkg::COLOUR_OFF);
          end
        end
      end else if (w.scan && w.frames < cfg_min_frame) begin
        seq_ind_active = 1'b0;
        seq_pulse_lit  = 1'b0;
        switch_mode(lsbs_pkg::MODE_SCAN);
        // scan blink toggle
        if (seq_scan_elapsed >= cfg_blink) begin
          seq_scan_elapsed = '0;
          seq_scan_lit     = !seq_scan_lit;
          show(seq_scan_lit ? lsbs_pkg::COLOUR_SCAN : lsbs_pkg::COLOUR_OFF);
        end
      end else begin
        seq_scan_lit   = 1'b0;
        seq_ind_active = 1'b0;
        seq_pulse_lit  = 1'b0;
        switch_mode(lsbs_pkg::MODE_IDLE);
      end
    end
    r.mode   = seq_mode;
    r.colour = seq_colour;
    r.wrote  = seq_wrote;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall and field compare
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected: mode %0d colour %0d write %0d",
                 status_mode, colour_code, colour_write);
          fails++;
        end else begin
          exp_r = expected_q.pop_front();
          if (status_mode !== exp_r.mode) begin
            $error("status_mode: expected %0d, got %0d", exp_r.mode, status_mode);
            fails++;
          end
          if (colour_code !== exp_r.colour) begin
            $error("colour_code: expected %0d, got %0d", exp_r.colour, colour_code);
            fails++;
          end
          if (colour_write !== exp_r.wrote) begin
            $error("colour_write: expected %0d, got %0d", exp_r.wrote, colour_write);
            fails++;
          end
          results_seen++;
          if (colour_write === 1'b1) colour_writes_seen++;
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  task automatic send_word(input word_t w, input bit has_typed = 1'b0,
                           input result_t typed_r = '{lsbs_pkg::MODE_OFF,
                                                      lsbs_pkg::COLOUR_OFF, 1'b0});
    result_t r;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= w.op;
    target_count <= w.target;
    busy_running <= w.busy;
    scan_running <= w.scan;
    frame_count  <= w.frames;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_word(w);
    expected_q.push_back(has_typed ? typed_r : r);
    words_sent++;
    if (w.op == lsbs_pkg::OP_ARM) arms_sent++;
  endtask

  // stop sending and let every expected word come back
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input lsbs_pkg::cfg_reg_t idx, input logic [15:0] val,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      lsbs_pkg::REG_LEDS_ENABLED:   cfg_enabled   = val[0];
      lsbs_pkg::REG_MIN_FRAME:      cfg_min_frame = val;
      lsbs_pkg::REG_IND_DELAY:      cfg_delay     = val;
      lsbs_pkg::REG_PULSE_INTERVAL: cfg_interval  = val;
      lsbs_pkg::REG_PULSE_LENGTH:   cfg_length    = val;
      lsbs_pkg::REG_SCAN_BLINK:     cfg_blink     = val;
      default: ;
    endcase
    reg_writes++;
    if (last) cfg_valid <= 1'b0;
  endtask

  // mostly short timings so that sequences run through, now and then an extreme
  function automatic logic [15:0] pick_timer(input int unsigned top);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return TimerMax;
    if (roll == 1) return '0;
    return 16'($urandom_range(0, top));
  endfunction

  task automatic random_config();
    logic [15:0] thr;
    thr = ($urandom_range(0, 7) == 0) ? pick_timer(8) : 16'($urandom_range(1, 8));
    write_reg(lsbs_pkg::REG_LEDS_ENABLED, {15'd0, ($urandom_range(0, 7) != 0)}, 1'b0);
    write_reg(lsbs_pkg::REG_MIN_FRAME, thr, 1'b0);
    write_reg(lsbs_pkg::REG_IND_DELAY, pick_timer(12), 1'b0);
    write_reg(lsbs_pkg::REG_PULSE_INTERVAL, pick_timer(10), 1'b0);
    write_reg(lsbs_pkg::REG_PULSE_LENGTH, pick_timer(6), 1'b0);
    write_reg(lsbs_pkg::REG_SCAN_BLINK, pick_timer(6), 1'b1);
  endtask

  function automatic word_t random_tick();
    word_t w;
    w.op     = lsbs_pkg::OP_TICK;
    w.target = 16'($urandom);
    w.busy   = 1'b0;
    w.scan   = 1'($urandom);
    if ($urandom_range(0, 7) == 0) w.frames = 16'($urandom);
    else w.frames = 16'($urandom_range(0, cfg_min_frame));
    return w;
  endfunction

  // one stretch of related words: indicator run, scan run, idle ticks or noise
  task automatic run_episode(output int n);
    word_t w;
    int    kind;
    int    len;
    kind = $urandom_range(0, 9);
    n = 0;
    if (kind <= 4) begin
      w = random_tick();
      w.op = lsbs_pkg::OP_ARM;
      if ($urandom_range(0, 9) == 0) w.target = 16'($urandom);
      else w.target = 16'($urandom_range(1, 4));
      send_word(w);
      n++;
      len = $urandom_range(5, 60);
      repeat (len) begin
        w = random_tick();
        w.busy = ($urandom_range(0, 19) != 0);
        send_word(w);
        n++;
      end
    end else if (kind <= 7) begin
      len = $urandom_range(5, 40);
      repeat (len) begin
        w = random_tick();
        w.busy = ($urandom_range(0, 29) == 0);
        w.scan = ($urandom_range(0, 19) != 0);
        if (cfg_min_frame != '0 && $urandom_range(0, 9) != 0)
          w.frames = 16'($urandom_range(0, cfg_min_frame - 1));
        send_word(w);
        n++;
      end
    end else if (kind == 8) begin
      len = $urandom_range(1, 10);
      repeat (len) begin
        send_word(random_tick());
        n++;
      end
    end else begin
      repeat (8) begin
        w.op     = ($urandom_range(0, 3) == 0) ? lsbs_pkg::OP_ARM : lsbs_pkg::OP_TICK;
        w.target = 16'($urandom);
        w.busy   = 1'($urandom);
        w.scan   = 1'($urandom);
        w.frames = 16'($urandom);
        send_word(w);
        n++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------

  task automatic add_word(input lsbs_pkg::op_t op, input logic [15:0] tgt, input logic b,
                          input logic s, input logic [15:0] f);
    dir_row_t r;
    r.is_reg   = 1'b0;
    r.reg_idx  = lsbs_pkg::REG_LEDS_ENABLED;
    r.reg_val  = '0;
    r.w.op     = op;
    r.w.target = tgt;
    r.w.busy   = b;
    r.w.scan   = s;
    r.w.frames = f;
    r.typed    = 1'b0;
    r.exp      = '{lsbs_pkg::MODE_OFF, lsbs_pkg::COLOUR_OFF, 1'b0};
    dir_rows.push_back(r);
  endtask

  task automatic add_reg(input lsbs_pkg::cfg_reg_t idx, input logic [15:0] val);
    add_word(lsbs_pkg::OP_TICK, '0, 1'b0, 1'b0, '0);
    dir_rows[dir_rows.size() - 1].is_reg  = 1'b1;
    dir_rows[dir_rows.size() - 1].reg_idx = idx;
    dir_rows[dir_rows.size() - 1].reg_val = val;
  endtask

  // pin the expected result of the last row
  task automatic expect_row(input lsbs_pkg::mode_t m, input lsbs_pkg::colour_t c,
                            input logic wr);
    dir_rows[dir_rows.size() - 1].typed = 1'b1;
    dir_rows[dir_rows.size() - 1].exp   = '{m, c, wr};
  endtask

  task automatic build_table();
    // reset registers: first tick goes idle, scan below the threshold, idle at and above it
    add_word(lsbs_pkg::OP_TICK, '0, 1'b0, 1'b0, '0);
    expect_row(lsbs_pkg::MODE_IDLE, lsbs_pkg::COLOUR_IDLE, 1'b1);
    add_word(lsbs_pkg::OP_TICK, '0, 1'b0, 1'b1, '0);
    expect_row(lsbs_pkg::MODE_SCAN, lsbs_pkg::COLOUR_SCAN, 1'b1);
    add_word(lsbs_pkg::OP_TICK, '0, 1'b0, 1'b1, 16'd3);
    expect_row(lsbs_pkg::MODE_IDLE, lsbs_pkg::COLOUR_IDLE, 1'b1);
    add_word(lsbs_pkg::OP_TICK, '0, 1'b0, 1'b1, 16'hFFFF);
    expect_row(lsbs_pkg::MODE_IDLE, lsbs_pkg::COLOUR_IDLE, 1'b0);
    // busy wins over scan; arming leaves the colour alone
    add_word(lsbs_pkg::OP_TICK, '0, 1'b1, 1'b1, '0);
    expect_row(lsbs_pkg::MODE_BUSY, lsbs_pkg::COLOUR_OFF, 1'b1);
    add_word(lsbs_pkg::OP_ARM, 16'hFFFF, 1'b0, 1'b0, '0);
    expect_row(lsbs_pkg::MODE_BUSY, lsbs_pkg::COLOUR_OFF, 1'b0);
    add_word(lsbs_pkg::OP_ARM, 16'h0000, 1'b1, 1'b1, 16'hFFFF);
    expect_row(lsbs_pkg::MODE_BUSY, lsbs_pkg::COLOUR_OFF, 1'b0);
    add_word(lsbs_pkg::OP_TICK, '0, 1'b1, 1'b0, '0);
    expect_row(lsbs_pkg::MODE_BUSY, lsbs_pkg::COLOUR_OFF, 1'b0);
    add_word(lsbs_pkg::OP_ARM, 16'hAAAA, 1'b0, 1'b0, '0);
    // a tick outside busy mode cancels the armed indicator
    add_word(lsbs_pkg::OP_TICK, 16'h5555, 1'b0, 1'b0, 16'hAAAA);
    expect_row(lsbs_pkg::MODE_IDLE, lsbs_pkg::COLOUR_IDLE, 1'b1);
    add_word(lsbs_pkg::OP_ARM, 16'h5555, 1'b0, 1'b0, '0);
    expect_row(lsbs_pkg::MODE_IDLE, lsbs_pkg::COLOUR_IDLE, 1'b0);
    add_word(lsbs_pkg::OP_TICK, '0, 1'b0, 1'b0, 16'h5555);
    expect_row(lsbs_pkg::MODE_IDLE, lsbs_pkg::COLOUR_IDLE, 1'b0);
    // zero timings: every compare met, scan toggles each tick
    add_reg(lsbs_pkg::REG_SCAN_BLINK, '0);
    add_reg(lsbs_pkg::REG_IND_DELAY, '0);
    add_reg(lsbs_pkg::REG_PULSE_INTERVAL, '0);
    add_reg(lsbs_pkg::REG_PULSE_LENGTH, '0);
    add_reg(lsbs_pkg::REG_MIN_FRAME, 16'hFFFF);
    add_word(lsbs_pkg::OP_TICK, '0, 1'b0, 1'b1, 16'hFFFE);
    add_word(lsbs_pkg::OP_TICK, '0, 1'b0, 1'b1, 16'h5555);
    add_word(lsbs_pkg::OP_ARM, 16'd2, 1'b0, 1'b0, '0);
    repeat (6) add_word(lsbs_pkg::OP_TICK, '0, 1'b1, 1'b0, '0);
    // master enable off
    add_reg(lsbs_pkg::REG_LEDS_ENABLED, '0);
    add_word(lsbs_pkg::OP_TICK, '0, 1'b1, 1'b1, '0);
    expect_row(lsbs_pkg::MODE_OFF, lsbs_pkg::COLOUR_OFF, 1'b1);
    add_word(lsbs_pkg::OP_ARM, 16'd5, 1'b0, 1'b0, '0);
    expect_row(lsbs_pkg::MODE_OFF, lsbs_pkg::COLOUR_OFF, 1'b0);
    add_word(lsbs_pkg::OP_TICK, '0, 1'b1, 1'b0, '0);
    expect_row(lsbs_pkg::MODE_OFF, lsbs_pkg::COLOUR_OFF, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int sent;
    int n;
    clear_sequencer();
    build_table();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed rows, registers written with nothing in flight
    for (int i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].is_reg) begin
        if (i == 0 || !dir_rows[i - 1].is_reg) settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val,
                  i == dir_rows.size() - 1 || !dir_rows[i + 1].is_reg);
      end else begin
        send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].exp);
      end
    end

    // random phases: receiver stalls heavy, then sender gaps heavy, then none
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      gap_pct   = (ph < 2) ? 36 : (ph < 4) ? 62 : 0;
      stall_pct = (ph < 2) ? 62 : (ph < 4) ? 36 : 0;
      random_config();
      sent = 0;
      while (sent < PhaseWords) begin
        run_episode(n);
        sent += n;
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("run covered %0d words (%0d arms), %0d results, %0d colour writes",
             words_sent, arms_sent, results_seen, colour_writes_seen);
    $display("and %0d register writes over directed and random phases",
             reg_writes);
    if (fails == 0) begin
      $display("tb_led_status_blink_sequencer_core OK");
    end else begin
      $display("tb_led_status_blink_sequencer_core NOT OK");
    end
    $finish;
  end

endmodule
